// ===== rtl/core/tmp_pkg.sv =====
// Shared types, constants and helpers for the trapezoid motion profile block.
package tmp_pkg;

    localparam int TIME_FRAC = 16;
    localparam int POS_W     = 32;
    localparam int ACC_W     = 31;
    localparam int TIME_W    = 16;
    localparam int FUNC_W    = 2;
    localparam int ADDR_W    = 4;

    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ABORT = 2'd2;

    typedef enum logic [1:0] {
        REG_MAX_ACCEL    = 2'd0,
        REG_MAX_VELOCITY = 2'd1,
        REG_MIN_HEIGHT   = 2'd2,
        REG_MAX_HEIGHT   = 2'd3
    } reg_idx_t;

    localparam logic [ACC_W-1:0]        RST_MAX_ACCEL    = 31'd1310720;
    localparam logic [ACC_W-1:0]        RST_MAX_VELOCITY = 31'd655360;
    localparam logic signed [POS_W-1:0] RST_MIN_HEIGHT   = 32'sd0;
    localparam logic signed [POS_W-1:0] RST_MAX_HEIGHT   = 32'sd3276800;

    typedef struct packed {
        logic [ACC_W-1:0]        max_accel;
        logic [ACC_W-1:0]        max_velocity;
        logic signed [POS_W-1:0] min_height;
        logic signed [POS_W-1:0] max_height;
    } cfg_t;

    // when the limits are crossed, values below the low limit get the low limit, all others the high limit
    function automatic logic signed [POS_W-1:0] clamp_height(
        input logic signed [POS_W-1:0] x,
        input logic signed [POS_W-1:0] lo,
        input logic signed [POS_W-1:0] hi
    );
        logic signed [POS_W-1:0] r;
        if (x < lo)
            r = lo;
        else if (x > hi)
            r = hi;
        else
            r = x;
        return r;
    endfunction

endpackage

// ===== rtl/core/tmp_if.sv =====
// Valid/ready channel interfaces for profile commands and results.
interface tmp_in_if
    import tmp_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  target_position;
    logic signed [POS_W-1:0]  measured_position;
    logic [TIME_W-1:0]        elapsed_time;

    modport source (
        output valid, func, target_position, measured_position, elapsed_time,
        input  ready
    );
    modport sink (
        input  valid, func, target_position, measured_position, elapsed_time,
        output ready
    );
endinterface

interface tmp_out_if
    import tmp_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  reference_position;
    logic                     moving_down;
    logic                     busy_res;
    logic                     done_res;

    modport source (
        output valid, reference_position, moving_down, busy_res, done_res,
        input  ready
    );
    modport sink (
        input  valid, reference_position, moving_down, busy_res, done_res,
        output ready
    );
endinterface

// ===== rtl/core/tmp_regs.sv =====
// APB configuration register file: acceleration, velocity cap, height limits.
module tmp_regs
    import tmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_accel    <= RST_MAX_ACCEL;
            cfg_reg.max_velocity <= RST_MAX_VELOCITY;
            cfg_reg.min_height   <= RST_MIN_HEIGHT;
            cfg_reg.max_height   <= RST_MAX_HEIGHT;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_MAX_ACCEL:    cfg_reg.max_accel    <= pwdata[ACC_W-1:0];
                REG_MAX_VELOCITY: cfg_reg.max_velocity <= pwdata[ACC_W-1:0];
                REG_MIN_HEIGHT:   cfg_reg.min_height   <= $signed(pwdata);
                REG_MAX_HEIGHT:   cfg_reg.max_height   <= $signed(pwdata);
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MAX_ACCEL:    prdata = {1'b0, cfg_reg.max_accel};
            REG_MAX_VELOCITY: prdata = {1'b0, cfg_reg.max_velocity};
            REG_MIN_HEIGHT:   prdata = cfg_reg.min_height;
            REG_MAX_HEIGHT:   prdata = cfg_reg.max_height;
        endcase
    end

endmodule

// ===== rtl/core/tmp_mul.sv =====
// Shared 32x32 unsigned multiplier with a registered product.
module tmp_mul
    import tmp_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [63:0] product
);

    logic [63:0] product_reg;

    assign product = product_reg;

    always_ff @(posedge clk)
    begin
        if (en)
            product_reg <= op_a * op_b;
    end

endmodule

// ===== rtl/core/trapezoid_motion_profile.sv =====
// Trapezoid profile generator: sequencer and datapath around one shared multiplier.
// Start: the command passes through S_START and S_WRITE; abort, no-op and idle tick go to S_WRITE.
// Active tick: S_MUL_VV, S_MUL_RA, S_MUL_DV, S_VEL, S_MUL_STEP, S_POS, S_CLAMP, S_WRITE.
// An active tick makes four passes through the shared multiplier. A new command is taken
// only in S_IDLE, and S_WRITE waits while the result register holds a stalled output.
// Reset (async, rst_n low): idle, position/velocity/goal zero, registers at defaults.
module trapezoid_motion_profile
    import tmp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    tmp_in_if.sink            in_ch,
    tmp_out_if.source         out_ch
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_MUL_VV,
        S_MUL_RA,
        S_MUL_DV,
        S_VEL,
        S_MUL_STEP,
        S_POS,
        S_CLAMP,
        S_WRITE
    } state_t;

    cfg_t cfg;

    state_t                  state_reg;
    logic signed [POS_W-1:0] tgt_reg;
    logic signed [POS_W-1:0] meas_reg;
    logic [TIME_W-1:0]       time_reg;

    logic signed [POS_W-1:0] goal_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic [ACC_W-1:0]        vel_reg;
    logic                    down_reg;
    logic                    active_reg;
    logic                    done_reg;

    logic [32:0]             rem1_reg;
    logic [63:0]             vv3_reg;
    logic [65:0]             rhs_reg;
    logic signed [POS_W-1:0] clip_reg;

    logic                    out_valid_reg;
    logic signed [POS_W-1:0] out_pos_reg;
    logic                    out_down_reg;
    logic                    out_busy_reg;
    logic                    out_done_reg;
    logic                    out_load;

    logic        mul_en;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    logic signed [POS_W-1:0] goal_c;
    logic signed [32:0]      rem;
    logic [32:0]             rem_abs;
    logic [ACC_W-1:0]        dv;
    logic                    brake;
    logic [ACC_W:0]          vsum;
    logic [ACC_W-1:0]        vel_new;
    logic [ACC_W-1:0]        step;
    logic signed [33:0]      pos_ext;
    logic signed [33:0]      goal_ext;
    logic signed [33:0]      clip_ext;
    logic signed [POS_W-1:0] pos_new;

    tmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tmp_mul u_mul (
        .clk     (clk),
        .en      (mul_en),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    assign in_ch.ready               = (state_reg == S_IDLE);
    assign out_ch.valid              = out_valid_reg;
    assign out_ch.reference_position = out_pos_reg;
    assign out_ch.moving_down        = out_down_reg;
    assign out_ch.busy_res           = out_busy_reg;
    assign out_ch.done_res           = out_done_reg;

    assign out_load = (state_reg == S_WRITE) && (!out_valid_reg || out_ch.ready);

    // multiplier operand select per step
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            S_MUL_VV:
            begin
                mul_a = {1'b0, vel_reg};
                mul_b = {1'b0, vel_reg};
            end
            S_MUL_RA:
            begin
                mul_a = rem1_reg[31:0];
                mul_b = {1'b0, cfg.max_accel};
            end
            S_MUL_DV:
            begin
                mul_a = {1'b0, cfg.max_accel};
                mul_b = {16'd0, time_reg};
            end
            S_MUL_STEP:
            begin
                mul_a = {1'b0, vel_reg};
                mul_b = {16'd0, time_reg};
            end
            S_IDLE, S_START, S_VEL, S_POS, S_CLAMP, S_WRITE:
                mul_en = 1'b0;
        endcase
    end

    always_comb
    begin
        goal_c  = clamp_height(tgt_reg, cfg.min_height, cfg.max_height);
        rem     = {goal_reg[31], goal_reg} - {pos_reg[31], pos_reg};
        rem_abs = rem[32] ? 33'(-rem) : 33'(rem);

        // floor(3vv / 2a) > rem  <=>  3vv >= (rem + 1) * 2a, for a nonzero
        dv    = mul_p[TIME_FRAC +: ACC_W];
        brake = (cfg.max_accel != '0) && ({2'b00, vv3_reg} >= rhs_reg);
        vsum  = {1'b0, vel_reg} + {1'b0, dv};
        if (brake)
            vel_new = (vel_reg > dv) ? vel_reg - dv : '0;
        else if (vsum > {1'b0, cfg.max_velocity})
            vel_new = cfg.max_velocity;
        else
            vel_new = vsum[ACC_W-1:0];

        step     = mul_p[TIME_FRAC +: ACC_W];
        goal_ext = {{2{goal_reg[31]}}, goal_reg};
        if (down_reg)
        begin
            pos_ext  = {{2{pos_reg[31]}}, pos_reg} - $signed({3'b000, step});
            clip_ext = (pos_ext < goal_ext) ? goal_ext : pos_ext;
        end
        else
        begin
            pos_ext  = {{2{pos_reg[31]}}, pos_reg} + $signed({3'b000, step});
            clip_ext = (pos_ext > goal_ext) ? goal_ext : pos_ext;
        end

        pos_new = clamp_height(clip_reg, cfg.min_height, cfg.max_height);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            goal_reg      <= '0;
            pos_reg       <= '0;
            vel_reg       <= '0;
            down_reg      <= 1'b0;
            active_reg    <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        tgt_reg  <= in_ch.target_position;
                        meas_reg <= in_ch.measured_position;
                        time_reg <= in_ch.elapsed_time;
                        priority if (in_ch.func == FUNC_START)
                            state_reg <= S_START;
                        else if (in_ch.func == FUNC_TICK && active_reg)
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= S_MUL_VV;
                        end
                        else if (in_ch.func == FUNC_ABORT)
                        begin
                            done_reg   <= active_reg;
                            active_reg <= 1'b0;
                            state_reg  <= S_WRITE;
                        end
                        else
                        begin
                            done_reg  <= 1'b0;
                            state_reg <= S_WRITE;
                        end
                    end
                end
                S_START:
                begin
                    goal_reg   <= goal_c;
                    pos_reg    <= meas_reg;
                    vel_reg    <= '0;
                    down_reg   <= (goal_c < meas_reg);
                    active_reg <= (goal_c != meas_reg);
                    done_reg   <= (goal_c == meas_reg);
                    state_reg  <= S_WRITE;
                end
                S_MUL_VV:
                begin
                    rem1_reg  <= rem_abs + 33'd1;
                    state_reg <= S_MUL_RA;
                end
                S_MUL_RA:
                begin
                    vv3_reg   <= mul_p + {mul_p[62:0], 1'b0};
                    state_reg <= S_MUL_DV;
                end
                S_MUL_DV:
                begin
                    // (rem + 1) * 2a; the high bit of rem + 1 only set when the low part is zero
                    rhs_reg   <= {({1'b0, mul_p} +
                                   (rem1_reg[32] ? {2'b00, cfg.max_accel, 32'd0} : 65'd0)),
                                  1'b0};
                    state_reg <= S_VEL;
                end
                S_VEL:
                begin
                    vel_reg   <= vel_new;
                    state_reg <= S_MUL_STEP;
                end
                S_MUL_STEP:
                    state_reg <= S_POS;
                S_POS:
                begin
                    clip_reg  <= clip_ext[POS_W-1:0];
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    pos_reg <= pos_new;
                    if (pos_new == goal_reg)
                    begin
                        active_reg <= 1'b0;
                        done_reg   <= 1'b1;
                    end
                    state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (out_load)
                    begin
                        out_pos_reg   <= pos_reg;
                        out_down_reg  <= down_reg;
                        out_busy_reg  <= active_reg;
                        out_done_reg  <= done_reg;
                        state_reg     <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule
